### sv/multi_stack_shared_pool_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shared-pool stack block
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_STACK_SHARED_POOL_MACROS_SVH
`define MULTI_STACK_SHARED_POOL_MACROS_SVH

// same-cycle implication
`define MSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Types and fixed field widths shared by the shared-pool stack block.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int LINE_W = 3;
  localparam int ID_W   = 32;
  localparam int CNT_W  = 7;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_COUNT = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

### sv/msp_in_if.sv
// ----------------------------------------------------------------------------
// msp_in_if
// Request channel: action, stack index and identifier with valid/ready.
// ----------------------------------------------------------------------------
interface msp_in_if;
  logic                           valid;
  logic                           ready;
  msp_pkg::action_t               action;
  logic [msp_pkg::LINE_W-1:0]     line;
  logic [msp_pkg::ID_W-1:0]       item_id;

  modport source (output valid, action, line, item_id, input ready);
  modport sink   (input valid, action, line, item_id, output ready);
endinterface

### sv/msp_out_if.sv
// ----------------------------------------------------------------------------
// msp_out_if
// Result channel: status, identifier and stack count with valid/ready.
// ----------------------------------------------------------------------------
interface msp_out_if;
  logic                           valid;
  logic                           ready;
  msp_pkg::status_t               status;
  logic [msp_pkg::ID_W-1:0]       item_out;
  logic [msp_pkg::CNT_W-1:0]      line_count;

  modport source (output valid, status, item_out, line_count, input ready);
  modport sink   (input valid, status, item_out, line_count, output ready);
endinterface

### sv/multi_stack_shared_pool.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_pool
// Several LIFO stacks linked through one shared slot pool with a free list.
// ----------------------------------------------------------------------------
//  channel  direction  transaction
//  in_ch    sink       action, line, item_id
//  out_ch   source     status, item_out, line_count
//
//  One transaction per cycle in and out while results are taken; a request
//  passes the input register, then the registered slot data and link reads.
//  The link read that a pop or a recycled push needs is bypassed from the
//  memory output into the next request, so no request waits on another.
//  Synchronous active-low reset; no clearing pass, freed slots are reused
//  first and never-used slots come from a fill counter once none are free.
//  A stalled result holds the whole pipe; the input stays ready while the
//  result register is empty or being taken.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool #(
  parameter int STACKS = 8,
  parameter int SLOTS  = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  msp_in_if.sink    in_ch,
  msp_out_if.source out_ch
);
  import msp_pkg::*;

  localparam int AW     = $clog2(SLOTS);
  localparam int SLOT_W = $clog2(SLOTS + 1);
  localparam int SW     = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(SLOTS);

  // pool and stack state
  logic [ID_W-1:0]   data_mem [SLOTS];
  logic [SLOT_W-1:0] link_mem [SLOTS];
  logic [ID_W-1:0]   data_q_r;
  logic [SLOT_W-1:0] link_q_r;
  logic [SLOT_W-1:0] head_r  [STACKS];
  logic [SLOT_W-1:0] count_r [STACKS];
  logic [SLOT_W-1:0] free_head_r;
  logic [SLOT_W-1:0] fresh_r;

  // input register
  logic              p1_valid_r;
  action_t           p1_action_r;
  logic [LINE_W-1:0] p1_line_r;
  logic [ID_W-1:0]   p1_item_r;

  // result register
  logic              p2_valid_r;
  status_t           p2_status_r;
  logic              p2_rd_r;
  logic [SLOT_W-1:0] p2_count_r;
  logic              p2_line_ok_r;
  logic              p2_hd_pend_r;
  logic [SW-1:0]     p2_hd_idx_r;
  logic              p2_fr_pend_r;

  status_t           p2_status_nxt;
  logic              p2_rd_nxt;
  logic [SLOT_W-1:0] p2_count_nxt;
  logic              p2_hd_pend_nxt;
  logic              p2_fr_pend_nxt;

  logic              en;
  logic              go;
  logic              line_ok;
  logic [SW+LINE_W-1:0] line_ext;
  logic [SW-1:0]     idx;
  logic              hd_byp;
  logic [SLOT_W-1:0] head_eff;
  logic [SLOT_W-1:0] free_eff;
  logic [SLOT_W-1:0] count_cur;
  logic              push_rec;
  logic              push_fresh;
  logic              push_ok;
  logic              head_ok;
  logic              do_push;
  logic              do_pop;
  logic [SLOT_W-1:0] push_slot;
  logic [AW-1:0]     rd_addr;
  logic [SLOT_W+CNT_W-1:0] cnt_ext;
  logic              full_rpt;
  logic              fresh_left;

  // pipe advance
  assign en          = !p2_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stack index and validity
  assign line_ok  = (32'(p1_line_r) < STACKS);
  assign line_ext = {{SW{1'b0}}, p1_line_r};
  assign idx      = line_ext[SW-1:0];

  // effective head and free list with bypass of the pending link read
  assign hd_byp    = p2_valid_r && p2_hd_pend_r && (p2_hd_idx_r == idx);
  assign head_eff  = hd_byp ? link_q_r : head_r[idx];
  assign free_eff  = (p2_valid_r && p2_fr_pend_r) ? link_q_r : free_head_r;
  assign count_cur = count_r[idx];

  // slot selection
  assign push_rec   = (free_eff < NULL_SLOT);
  assign push_fresh = !push_rec && (fresh_r < NULL_SLOT);
  assign push_ok    = push_rec || push_fresh;
  assign push_slot  = push_rec ? free_eff : fresh_r;
  assign head_ok    = (head_eff < NULL_SLOT);
  assign rd_addr    = (p1_action_r == ACT_PUSH) ? push_slot[AW-1:0] : head_eff[AW-1:0];

  assign go      = en && p1_valid_r && line_ok;
  assign do_push = go && (p1_action_r == ACT_PUSH) && push_ok;
  assign do_pop  = go && (p1_action_r == ACT_POP) && head_ok;

  // result of the request in the input register
  always_comb begin
    p2_status_nxt  = ST_OK;
    p2_rd_nxt      = 1'b0;
    p2_count_nxt   = '0;
    p2_hd_pend_nxt = 1'b0;
    p2_fr_pend_nxt = 1'b0;
    if (line_ok) begin
      p2_count_nxt = count_cur;
      case (p1_action_r)
        ACT_PUSH: begin
          if (push_ok) begin
            p2_count_nxt   = count_cur + SLOT_W'(1);
            p2_fr_pend_nxt = push_rec;
          end else begin
            p2_status_nxt = ST_FULL;
          end
        end
        ACT_POP: begin
          if (head_ok) begin
            p2_rd_nxt      = 1'b1;
            p2_hd_pend_nxt = 1'b1;
            if (count_cur != '0) begin
              p2_count_nxt = count_cur - SLOT_W'(1);
            end
          end else begin
            p2_status_nxt = ST_EMPTY;
          end
        end
        ACT_PEEK: begin
          if (head_ok) begin
            p2_rd_nxt = 1'b1;
          end else begin
            p2_status_nxt = ST_EMPTY;
          end
        end
        default: begin
          p2_status_nxt = ST_OK;
        end
      endcase
    end else begin
      case (p1_action_r)
        ACT_PUSH: p2_status_nxt = ST_FULL;
        ACT_POP:  p2_status_nxt = ST_EMPTY;
        ACT_PEEK: p2_status_nxt = ST_EMPTY;
        default:  p2_status_nxt = ST_OK;
      endcase
    end
  end

  // slot data memory
  always_ff @(posedge clk) begin
    if (do_push) begin
      data_mem[push_slot[AW-1:0]] <= p1_item_r;
    end
    if (en) begin
      data_q_r <= data_mem[rd_addr];
    end
  end

  // slot link memory, read before write
  always_ff @(posedge clk) begin
    if (do_push) begin
      link_mem[push_slot[AW-1:0]] <= head_eff;
    end else if (do_pop) begin
      link_mem[head_eff[AW-1:0]] <= free_eff;
    end
    if (en) begin
      link_q_r <= link_mem[rd_addr];
    end
  end

  // stack heads, counts and free list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STACKS; i++) begin
        head_r[i]  <= NULL_SLOT;
        count_r[i] <= '0;
      end
      free_head_r <= NULL_SLOT;
      fresh_r     <= '0;
    end else if (en) begin
      // pending updates from the result stage first, newer request wins
      if (p2_valid_r && p2_hd_pend_r) begin
        head_r[p2_hd_idx_r] <= link_q_r;
      end
      if (p2_valid_r && p2_fr_pend_r) begin
        free_head_r <= link_q_r;
      end
      if (go) begin
        count_r[idx] <= p2_count_nxt;
      end
      if (do_push) begin
        head_r[idx] <= push_slot;
        if (push_fresh) begin
          fresh_r <= fresh_r + SLOT_W'(1);
        end
      end
      if (do_pop) begin
        free_head_r <= head_eff;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_action_r <= in_ch.action;
      p1_line_r   <= in_ch.line;
      p1_item_r   <= in_ch.item_id;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r   <= 1'b0;
      p2_hd_pend_r <= 1'b0;
      p2_fr_pend_r <= 1'b0;
    end else if (en) begin
      p2_valid_r   <= p1_valid_r;
      p2_hd_pend_r <= p1_valid_r && p2_hd_pend_nxt;
      p2_fr_pend_r <= p1_valid_r && p2_fr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_status_r  <= p2_status_nxt;
      p2_rd_r      <= p2_rd_nxt;
      p2_count_r   <= p2_count_nxt;
      p2_line_ok_r <= line_ok;
      p2_hd_idx_r  <= idx;
    end
  end

  // result channel
  assign cnt_ext           = {{CNT_W{1'b0}}, p2_count_r};
  assign out_ch.valid      = p2_valid_r;
  assign out_ch.status     = p2_status_r;
  assign out_ch.item_out   = p2_rd_r ? data_q_r : '0;
  assign out_ch.line_count = cnt_ext[CNT_W-1:0];

  // checks
  assign full_rpt   = p2_valid_r && (p2_status_r == ST_FULL);
  assign fresh_left = p2_line_ok_r && (fresh_r != NULL_SLOT);

`include "multi_stack_shared_pool_macros.svh"

  `MSP_ASSERT_NOW(a_fresh_bound, 1'b1, fresh_r <= NULL_SLOT, "fill counter beyond pool size")
  `MSP_ASSERT_NEXT(a_pop_pending, do_pop, p2_valid_r && p2_hd_pend_r, "pop lost its head update")
  `MSP_ASSERT_NOW(a_full_real, full_rpt, !fresh_left, "full reported with fresh slots left")

endmodule
